// ----- rtl/cc_pkg.sv -----
// Shared constants, types and width helpers for the circumcircle pipeline.
package cc_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COORD_MAX      = 16;
   localparam int IN_W           = 12;
   localparam int OUT_W          = 24;
   localparam int QBITS          = 24;
   localparam int RAD_SHIFT      = 16;
   localparam int FRONT_STAGES   = 5;

   localparam logic [OUT_W-1:0] SAT_POS = 24'h7FFFFF;
   localparam logic [OUT_W-1:0] SAT_NEG = 24'h800000;
   localparam logic [OUT_W-1:0] RAD_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic signed [OUT_W-1:0] center_x;
      logic signed [OUT_W-1:0] center_y;
      logic [OUT_W-1:0]        radius_q8;
      logic                    degenerate;
      logic                    saturated;
   } result_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic deg;
      logic ov_x;
      logic ov_y;
      logic ov_r;
   } flags_type;

   // signed width of U
   function automatic int u_width(int c);
      return 2 * c + 5;
   endfunction

   // signed width of the centre numerators
   function automatic int num_width(int c);
      return 3 * c + 5;
   endfunction

   // root bits of the square root (half the padded radicand width)
   function automatic int root_width(int c);
      return 3 * c + 10;
   endfunction

   function automatic logic [COORD_MAX-1:0] widen(logic [IN_W-1:0] v);
      return {{(COORD_MAX-IN_W){1'b0}}, v};
   endfunction

endpackage

// ----- rtl/cc_front.sv -----
// Five-stage front end: U, centre numerators and the radius radicand.
module cc_front #(
   parameter int  COORD_BITS = cc_pkg::COORD_BITS_DEF,
   localparam int C    = COORD_BITS,
   localparam int DW   = C + 1,
   localparam int PW   = 2 * DW,
   localparam int SQW  = 2 * C,
   localparam int MW   = 2 * C + 1,
   localparam int DSW  = 2 * C + 1,
   localparam int UW   = cc_pkg::u_width(C),
   localparam int UW1  = UW - 1,
   localparam int TW   = MW + 1 + DW,
   localparam int NW   = cc_pkg::num_width(C),
   localparam int HW   = DSW,
   localparam int P12W = 2 * DSW,
   localparam int PRW  = P12W + HW,
   localparam int LWE  = 2 * cc_pkg::root_width(C)
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [cc_pkg::IN_W-1:0] src_ax,
   input  logic [cc_pkg::IN_W-1:0] src_ay,
   input  logic [cc_pkg::IN_W-1:0] src_bx,
   input  logic [cc_pkg::IN_W-1:0] src_by,
   input  logic [cc_pkg::IN_W-1:0] src_cx,
   input  logic [cc_pkg::IN_W-1:0] src_cy,
   output logic [LWE-1:0]          lim_ff,
   output logic [NW-1:0]           nx_mag_ff,
   output logic [NW-1:0]           ny_mag_ff,
   output logic [UW-1:0]           u_mag_ff,
   output logic                    neg_x_ff,
   output logic                    neg_y_ff,
   output logic                    deg_ff
);

   logic [cc_pkg::COORD_MAX-1:0] wide [6];
   logic signed [DW-1:0]  sc [6];
   logic signed [PW-1:0]  ee [6];

   // stage 1
   logic signed [DW-1:0]  e_in [6], e_ff [6];
   logic signed [PW-1:0]  ut_in [3], ut_ff [3];
   logic [SQW-1:0]        sq_in [6], sq_ff [6];
   logic [SQW-1:0]        es_in [6], es_ff [6];
   // stage 2
   logic signed [UW1-1:0] us;
   logic signed [UW-1:0]  u2_in, u2_ff;
   logic [MW-1:0]         m_in [3], m_ff [3];
   logic [DSW-1:0]        d_in [3], d_ff [3];
   logic signed [DW-1:0]  e2_ff [6];
   // stage 3
   logic signed [TW-1:0]  nxt_in [3], nxt_ff [3];
   logic signed [TW-1:0]  nyt_in [3], nyt_ff [3];
   logic [P12W-1:0]       p12_in, p12_ff;
   logic [DSW-1:0]        d3_ff;
   logic signed [UW-1:0]  u3_ff;
   // stage 4
   logic signed [NW-1:0]  nx_in, nx_ff, ny_in, ny_ff;
   logic [P12W-1:0]       plo_in, plo_ff, phi_in, phi_ff;
   logic signed [UW-1:0]  u4_ff;
   // stage 5
   logic [PRW-1:0]        prod;
   logic [LWE-1:0]        lim_in;
   logic [NW-1:0]         nx_mag_in, ny_mag_in;
   logic [UW-1:0]         u_mag_in;
   logic                  neg_x_in, neg_y_in, deg_in;

   assign wide[0] = cc_pkg::widen(src_ax);
   assign wide[1] = cc_pkg::widen(src_ay);
   assign wide[2] = cc_pkg::widen(src_bx);
   assign wide[3] = cc_pkg::widen(src_by);
   assign wide[4] = cc_pkg::widen(src_cx);
   assign wide[5] = cc_pkg::widen(src_cy);

   // e: cx-bx, ax-cx, bx-ax, by-cy, cy-ay, ay-by
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         sc[k]    = $signed({1'b0, wide[k][C-1:0]});
         sq_in[k] = SQW'(wide[k][C-1:0]) * SQW'(wide[k][C-1:0]);
      end
      e_in[0] = sc[4] - sc[2];
      e_in[1] = sc[0] - sc[4];
      e_in[2] = sc[2] - sc[0];
      e_in[3] = sc[3] - sc[5];
      e_in[4] = sc[5] - sc[1];
      e_in[5] = sc[1] - sc[3];
      for (int k = 0; k < 6; k++) begin
         ee[k]    = PW'(e_in[k]) * PW'(e_in[k]);
         es_in[k] = ee[k][SQW-1:0];
      end
      for (int k = 0; k < 3; k++) begin
         ut_in[k] = PW'(sc[2*k]) * PW'(e_in[3+k]);
      end
   end

   always_comb begin
      us    = UW1'(ut_ff[0]) + UW1'(ut_ff[1]) + UW1'(ut_ff[2]);
      u2_in = {us, 1'b0};
      for (int k = 0; k < 3; k++) begin
         m_in[k] = MW'(sq_ff[2*k]) + MW'(sq_ff[2*k+1]);
      end
      d_in[0] = DSW'(es_ff[2]) + DSW'(es_ff[5]);   // |AB|^2
      d_in[1] = DSW'(es_ff[0]) + DSW'(es_ff[3]);   // |BC|^2
      d_in[2] = DSW'(es_ff[1]) + DSW'(es_ff[4]);   // |CA|^2
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nxt_in[k] = TW'($signed({1'b0, m_ff[k]})) * TW'(e2_ff[3+k]);
         nyt_in[k] = TW'($signed({1'b0, m_ff[k]})) * TW'(e2_ff[k]);
      end
      p12_in = P12W'(d_ff[0]) * P12W'(d_ff[1]);
   end

   // 50-bit by 25-bit product at the default COORD_BITS of 12, split into two halves
   always_comb begin
      nx_in  = NW'(nxt_ff[0]) + NW'(nxt_ff[1]) + NW'(nxt_ff[2]);
      ny_in  = NW'(nyt_ff[0]) + NW'(nyt_ff[1]) + NW'(nyt_ff[2]);
      plo_in = P12W'(p12_ff[HW-1:0]) * P12W'(d3_ff);
      phi_in = P12W'(p12_ff[P12W-1:HW]) * P12W'(d3_ff);
   end

   always_comb begin
      prod      = (PRW'(phi_ff) << HW) + PRW'(plo_ff);
      lim_in    = LWE'(prod) << cc_pkg::RAD_SHIFT;
      nx_mag_in = nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
      ny_mag_in = ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
      u_mag_in  = u4_ff[UW-1] ? UW'(-u4_ff) : UW'(u4_ff);
      neg_x_in  = nx_ff[NW-1] ^ u4_ff[UW-1];
      neg_y_in  = ny_ff[NW-1] ^ u4_ff[UW-1];
      deg_in    = (u4_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff   <= e_in;
         ut_ff  <= ut_in;
         sq_ff  <= sq_in;
         es_ff  <= es_in;
         u2_ff  <= u2_in;
         m_ff   <= m_in;
         d_ff   <= d_in;
         e2_ff  <= e_ff;
         nxt_ff <= nxt_in;
         nyt_ff <= nyt_in;
         p12_ff <= p12_in;
         d3_ff  <= d_ff[2];
         u3_ff  <= u2_ff;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         u4_ff  <= u3_ff;
         lim_ff    <= lim_in;
         nx_mag_ff <= nx_mag_in;
         ny_mag_ff <= ny_mag_in;
         u_mag_ff  <= u_mag_in;
         neg_x_ff  <= neg_x_in;
         neg_y_ff  <= neg_y_in;
         deg_ff    <= deg_in;
      end
   end

endmodule

// ----- rtl/cc_sqrt_cell.sv -----
// One restoring square-root cell: settles one root bit per stage.
module cc_sqrt_cell #(
   parameter int  X_W    = 2 * cc_pkg::root_width(cc_pkg::COORD_BITS_DEF),
   parameter int  ROOT_W = cc_pkg::root_width(cc_pkg::COORD_BITS_DEF),
   localparam int RW     = ROOT_W + 2,
   localparam int CURW   = RW + 2
) (
   input  logic              clock,
   input  logic              en,
   input  logic [X_W-1:0]    src_x,
   input  logic [RW-1:0]     src_rem,
   input  logic [ROOT_W-1:0] src_root,
   output logic [X_W-1:0]    x_ff,
   output logic [RW-1:0]     rem_ff,
   output logic [ROOT_W-1:0] root_ff
);

   logic [CURW-1:0]   cur, trial, diff;
   logic              ge;
   logic [X_W-1:0]    x_in;
   logic [RW-1:0]     rem_in;
   logic [ROOT_W-1:0] root_in;

   always_comb begin
      cur     = {src_rem, src_x[X_W-1:X_W-2]};
      trial   = CURW'({src_root, 2'b01});
      ge      = (cur >= trial);
      diff    = cur - trial;
      rem_in  = ge ? diff[RW-1:0] : cur[RW-1:0];
      root_in = {src_root[ROOT_W-2:0], ge};
      x_in    = src_x << 2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

endmodule

// ----- rtl/cc_div_cell.sv -----
// One restoring divider cell: settles quotient bit SHIFT.
module cc_div_cell #(
   parameter int  NUM_W = cc_pkg::num_width(cc_pkg::COORD_BITS_DEF),
   parameter int  DEN_W = cc_pkg::u_width(cc_pkg::COORD_BITS_DEF),
   parameter int  SHIFT = cc_pkg::QBITS - 1,
   localparam int CW    = NUM_W + DEN_W + SHIFT + 1
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [NUM_W-1:0]         src_n,
   input  logic [cc_pkg::QBITS-1:0] src_q,
   input  logic [DEN_W-1:0]         den,
   output logic [NUM_W-1:0]         n_ff,
   output logic [cc_pkg::QBITS-1:0] q_ff
);

   logic [CW-1:0]            dsh, diff;
   logic                     ge;
   logic [NUM_W-1:0]         n_in;
   logic [cc_pkg::QBITS-1:0] q_in;

   always_comb begin
      dsh  = CW'(den) << SHIFT;
      ge   = (CW'(src_n) >= dsh);
      diff = CW'(src_n) - dsh;
      n_in = ge ? diff[NUM_W-1:0] : src_n;
      q_in = {src_q[cc_pkg::QBITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         q_ff <= q_in;
      end
   end

endmodule

// ----- rtl/circumcircle_from_three_points.sv -----
// Top level: circumcircle centre and Q.8 radius of three points, fully pipelined.
// The square-root chain of 3*COORD_BITS+10 cells is the longest stretch of the pipeline.
// Throughput: one word per cycle; a two-entry output stage (register plus skid)
//   keeps accepting while a result waits, stalling the chain only when both are full.
// Reset: synchronous, active high; clears all valid bits, payload registers hold.
module circumcircle_from_three_points #(
   parameter int COORD_BITS = cc_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cc_pkg::IN_W-1:0]         req_point_a_x,
   input  logic [cc_pkg::IN_W-1:0]         req_point_a_y,
   input  logic [cc_pkg::IN_W-1:0]         req_point_b_x,
   input  logic [cc_pkg::IN_W-1:0]         req_point_b_y,
   input  logic [cc_pkg::IN_W-1:0]         req_point_c_x,
   input  logic [cc_pkg::IN_W-1:0]         req_point_c_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [cc_pkg::OUT_W-1:0] rsp_center_x,
   output logic signed [cc_pkg::OUT_W-1:0] rsp_center_y,
   output logic [cc_pkg::OUT_W-1:0]        rsp_radius_q8,
   output logic                            rsp_degenerate,
   output logic                            rsp_saturated
);

   localparam int QB    = cc_pkg::QBITS;
   localparam int NW    = cc_pkg::num_width(COORD_BITS);
   localparam int UW    = cc_pkg::u_width(COORD_BITS);
   localparam int NSQ   = cc_pkg::root_width(COORD_BITS);
   localparam int LWE   = 2 * NSQ;
   localparam int RW    = NSQ + 2;
   localparam int M1    = (NW > NSQ) ? NW : NSQ;
   localparam int CMPW  = ((M1 > UW + QB) ? M1 : UW + QB) + 1;
   localparam int TOTAL = cc_pkg::FRONT_STAGES + NSQ + 1 + QB;

   // Stall control: the whole chain moves unless the skid entry is occupied.
   logic                 en;
   logic [TOTAL-1:0]     vld_ff;
   logic                 leave;

   // front end outputs
   logic [LWE-1:0]       fr_lim;
   logic [NW-1:0]        fr_nx, fr_ny;
   logic [UW-1:0]        fr_u;
   logic                 fr_neg_x, fr_neg_y, fr_deg;

   // square-root chain with the centre terms riding alongside
   logic [LWE-1:0]       sq_x    [NSQ];
   logic [RW-1:0]        sq_rem  [NSQ];
   logic [NSQ-1:0]       sq_root [NSQ];
   logic [NW-1:0]        dl_nx_ff [NSQ];
   logic [NW-1:0]        dl_ny_ff [NSQ];
   logic [UW-1:0]        dl_u_ff  [NSQ];
   cc_pkg::flags_type    dl_fl_ff [NSQ];

   // range check ahead of the dividers
   logic [NW-1:0]        pc_nx_ff, pc_ny_ff;
   logic [NSQ-1:0]       pc_r_ff;
   logic [UW-1:0]        pc_u_ff;
   cc_pkg::flags_type    pc_fl_in, pc_fl_ff;
   logic [CMPW-1:0]      u_top;

   // divider chain
   logic [NW-1:0]        dvx_n [QB];
   logic [NW-1:0]        dvy_n [QB];
   logic [NSQ-1:0]       dvr_n [QB];
   logic [QB-1:0]        dvx_q [QB];
   logic [QB-1:0]        dvy_q [QB];
   logic [QB-1:0]        dvr_q [QB];
   logic [UW-1:0]        sd_u_ff  [QB];
   cc_pkg::flags_type    sd_fl_ff [QB];

   // output stage
   cc_pkg::result_type   res;
   cc_pkg::result_type   out_ff, skid_ff;
   logic                 out_vld_ff, skid_vld_ff;
   logic [QB-1:0]        qx, qy, qr;
   cc_pkg::flags_type    fl;
   logic                 sat_x, sat_y;

   assign en        = !skid_vld_ff;
   assign req_ready = en;
   assign leave     = en && vld_ff[TOTAL-1];

   cc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .en        (en),
      .src_ax    (req_point_a_x),
      .src_ay    (req_point_a_y),
      .src_bx    (req_point_b_x),
      .src_by    (req_point_b_y),
      .src_cx    (req_point_c_x),
      .src_cy    (req_point_c_y),
      .lim_ff    (fr_lim),
      .nx_mag_ff (fr_nx),
      .ny_mag_ff (fr_ny),
      .u_mag_ff  (fr_u),
      .neg_x_ff  (fr_neg_x),
      .neg_y_ff  (fr_neg_y),
      .deg_ff    (fr_deg)
   );

   // isqrt(65536 * |AB|^2 |BC|^2 |CA|^2), one root bit per cell
   for (genvar k = 0; k < NSQ; k++) begin : g_sq
      if (k == 0) begin : g_first
         cc_sqrt_cell #(.X_W(LWE), .ROOT_W(NSQ)) u_cell (
            .clock    (clock),
            .en       (en),
            .src_x    (fr_lim),
            .src_rem  ('0),
            .src_root ('0),
            .x_ff     (sq_x[k]),
            .rem_ff   (sq_rem[k]),
            .root_ff  (sq_root[k])
         );
      end else begin : g_next
         cc_sqrt_cell #(.X_W(LWE), .ROOT_W(NSQ)) u_cell (
            .clock    (clock),
            .en       (en),
            .src_x    (sq_x[k-1]),
            .src_rem  (sq_rem[k-1]),
            .src_root (sq_root[k-1]),
            .x_ff     (sq_x[k]),
            .rem_ff   (sq_rem[k]),
            .root_ff  (sq_root[k])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_nx_ff[0] <= fr_nx;
         dl_ny_ff[0] <= fr_ny;
         dl_u_ff[0]  <= fr_u;
         dl_fl_ff[0] <= '{neg_x: fr_neg_x, neg_y: fr_neg_y, deg: fr_deg,
                          ov_x: 1'b0, ov_y: 1'b0, ov_r: 1'b0};
         for (int k = 1; k < NSQ; k++) begin
            dl_nx_ff[k] <= dl_nx_ff[k-1];
            dl_ny_ff[k] <= dl_ny_ff[k-1];
            dl_u_ff[k]  <= dl_u_ff[k-1];
            dl_fl_ff[k] <= dl_fl_ff[k-1];
         end
      end
   end

   // A quotient of 2^24 or more saturates in any case; flag it up front so the
   // dividers only need 24 quotient bits.
   always_comb begin
      u_top         = CMPW'(dl_u_ff[NSQ-1]) << QB;
      pc_fl_in      = dl_fl_ff[NSQ-1];
      pc_fl_in.ov_x = (CMPW'(dl_nx_ff[NSQ-1]) >= u_top);
      pc_fl_in.ov_y = (CMPW'(dl_ny_ff[NSQ-1]) >= u_top);
      pc_fl_in.ov_r = (CMPW'(sq_root[NSQ-1]) >= u_top);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_nx_ff <= dl_nx_ff[NSQ-1];
         pc_ny_ff <= dl_ny_ff[NSQ-1];
         pc_r_ff  <= sq_root[NSQ-1];
         pc_u_ff  <= dl_u_ff[NSQ-1];
         pc_fl_ff <= pc_fl_in;
      end
   end

   // three dividers side by side, all by |U|, MSB first
   for (genvar k = 0; k < QB; k++) begin : g_dv
      logic [NW-1:0]  nx_src, ny_src;
      logic [NSQ-1:0] nr_src;
      logic [QB-1:0]  qx_src, qy_src, qr_src;
      logic [UW-1:0]  d_src;

      if (k == 0) begin : g_first
         assign nx_src = pc_nx_ff;
         assign ny_src = pc_ny_ff;
         assign nr_src = pc_r_ff;
         assign qx_src = '0;
         assign qy_src = '0;
         assign qr_src = '0;
         assign d_src  = pc_u_ff;
      end else begin : g_next
         assign nx_src = dvx_n[k-1];
         assign ny_src = dvy_n[k-1];
         assign nr_src = dvr_n[k-1];
         assign qx_src = dvx_q[k-1];
         assign qy_src = dvy_q[k-1];
         assign qr_src = dvr_q[k-1];
         assign d_src  = sd_u_ff[k-1];
      end

      cc_div_cell #(.NUM_W(NW), .DEN_W(UW), .SHIFT(QB-1-k)) u_x (
         .clock (clock), .en (en), .src_n (nx_src), .src_q (qx_src),
         .den (d_src), .n_ff (dvx_n[k]), .q_ff (dvx_q[k])
      );
      cc_div_cell #(.NUM_W(NW), .DEN_W(UW), .SHIFT(QB-1-k)) u_y (
         .clock (clock), .en (en), .src_n (ny_src), .src_q (qy_src),
         .den (d_src), .n_ff (dvy_n[k]), .q_ff (dvy_q[k])
      );
      cc_div_cell #(.NUM_W(NSQ), .DEN_W(UW), .SHIFT(QB-1-k)) u_r (
         .clock (clock), .en (en), .src_n (nr_src), .src_q (qr_src),
         .den (d_src), .n_ff (dvr_n[k]), .q_ff (dvr_q[k])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            sd_u_ff[k]  <= d_src;
            sd_fl_ff[k] <= (k == 0) ? pc_fl_ff : sd_fl_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // sign, truncation toward zero and clipping
   always_comb begin
      qx    = dvx_q[QB-1];
      qy    = dvy_q[QB-1];
      qr    = dvr_q[QB-1];
      fl    = sd_fl_ff[QB-1];
      sat_x = fl.ov_x || (qx[QB-1] && (!fl.neg_x || (|qx[QB-2:0])));
      sat_y = fl.ov_y || (qy[QB-1] && (!fl.neg_y || (|qy[QB-2:0])));
      res   = '0;
      if (fl.deg) begin
         res.degenerate = 1'b1;
      end else begin
         res.center_x  = sat_x ? (fl.neg_x ? cc_pkg::SAT_NEG : cc_pkg::SAT_POS)
                               : (fl.neg_x ? -qx : qx);
         res.center_y  = sat_y ? (fl.neg_y ? cc_pkg::SAT_NEG : cc_pkg::SAT_POS)
                               : (fl.neg_y ? -qy : qy);
         res.radius_q8 = fl.ov_r ? cc_pkg::RAD_MAX : qr;
         res.saturated = sat_x || sat_y || fl.ov_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[TOTAL-2:0], req_valid};
         end
         if (skid_vld_ff) begin
            if (rsp_ready) begin
               skid_vld_ff <= 1'b0;
            end
         end else if (leave) begin
            if (out_vld_ff && !rsp_ready) begin
               skid_vld_ff <= 1'b1;
            end else begin
               out_vld_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (leave) begin
         if (out_vld_ff && !rsp_ready) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_center_x   = out_ff.center_x;
   assign rsp_center_y   = out_ff.center_y;
   assign rsp_radius_q8  = out_ff.radius_q8;
   assign rsp_degenerate = out_ff.degenerate;
   assign rsp_saturated  = out_ff.saturated;

endmodule

// ----- rtl/cc_checker.sv -----
// Port-level checks for the circumcircle block, bound to the top level.
module cc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [cc_pkg::IN_W-1:0]         req_point_a_x,
   input logic [cc_pkg::IN_W-1:0]         req_point_a_y,
   input logic [cc_pkg::IN_W-1:0]         req_point_b_x,
   input logic [cc_pkg::IN_W-1:0]         req_point_b_y,
   input logic [cc_pkg::IN_W-1:0]         req_point_c_x,
   input logic [cc_pkg::IN_W-1:0]         req_point_c_y,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [cc_pkg::OUT_W-1:0] rsp_center_x,
   input logic signed [cc_pkg::OUT_W-1:0] rsp_center_y,
   input logic [cc_pkg::OUT_W-1:0]        rsp_radius_q8,
   input logic                            rsp_degenerate,
   input logic                            rsp_saturated
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_center_x)
         && $stable(rsp_center_y) && $stable(rsp_radius_q8)
         && $stable(rsp_degenerate) && $stable(rsp_saturated))
      else $error("result word changed while stalled");

   // a degenerate (collinear) word has all other fields zero
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_center_x == 0 && rsp_center_y == 0
         && rsp_radius_q8 == 0 && !rsp_saturated)
      else $error("degenerate word with nonzero fields");

   // input back-pressure only while a result is held at the output
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty output");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind circumcircle_from_three_points cc_checker u_cc_checker (.*);
